@@ src/cubic_spline_evaluator_defines.svh @@
// assertion macros for the spline evaluator
`ifndef CUBIC_SPLINE_EVALUATOR_DEFINES_SVH
`define CUBIC_SPLINE_EVALUATOR_DEFINES_SVH
// implication checked on every clock edge outside reset
`define CSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define CSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ src/cse_pkg.sv @@
`timescale 1ns / 1ps
package cse_pkg;
	localparam int MaxKnotsDef = 64;
	localparam int NumKnotsReset = 2;
	localparam logic CmdWrite = 1'b0;
	localparam logic CmdEval = 1'b1;
	localparam logic [1:0] RangeIn = 2'd0;
	localparam logic [1:0] RangeBelow = 2'd1;
	localparam logic [1:0] RangeAbove = 2'd2;
	localparam logic [0:0] RegNumKnots = 1'b0;

	typedef struct packed {
		logic command;
		logic [5:0] entry_index;
		logic signed [31:0] knot_pos;
		logic signed [31:0] coef_a;
		logic signed [31:0] coef_b;
		logic signed [31:0] coef_c;
		logic signed [31:0] coef_d;
		logic signed [31:0] query_t;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] first_deriv;
		logic signed [31:0] second_deriv;
		logic signed [31:0] third_deriv;
		logic [1:0] range_status;
		logic [5:0] segment_index;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_WRITE, ST_CHK0, ST_CHKN, ST_SRCH, ST_SWAIT,
		ST_FETCH, ST_FWAIT, ST_M1, ST_M2, ST_M3, ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input item
		logic wr;        // write table entry
		logic rd_first;  // read entry 0
		logic rd_last;   // read entry n-1
		logic chk_first; // compare with entry 0
		logic chk_last;  // compare with entry n-1
		logic rd_mid;    // read search midpoint
		logic step;      // bisection step
		logic rd_seg;    // read segment entry
		logic cap_seg;   // latch segment operands
		logic m1;
		logic m2;
		logic m3;
		logic fin;       // issue result
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_eval;
		logic below;
		logic above;
		logic srch_done;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -36'sh0_8000_0000) return -32'sh8000_0000;
		return v[31:0];
	endfunction

	// round a Q32.32 style product to Q16.16, ties up
	function automatic logic signed [48:0] rnd16(input logic signed [64:0] p);
		logic signed [64:0] v;
		v = p + 65'sd32768;
		return v[64:16];
	endfunction

	function automatic logic signed [31:0] sat49(input logic signed [51:0] v);
		if (v > 52'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -52'sh8000_0000) return -32'sh8000_0000;
		return v[31:0];
	endfunction
endpackage

@@ src/cse_ram.sv @@
`timescale 1ns / 1ps
module cse_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ src/cse_ctrl.sv @@
`timescale 1ns / 1ps
module cse_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input cse_pkg::sts_t sts,
	output logic busy,
	output cse_pkg::ctl_t ctl
);
	import cse_pkg::*;
	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_n = ST_WRITE;
			ST_WRITE: state_n = sts.is_eval ? ST_CHK0 : ST_IDLE;
			ST_CHK0: state_n = ST_CHKN;
			ST_CHKN: state_n = ST_SRCH;
			ST_SRCH: begin
				if (sts.below || sts.above) state_n = ST_DONE;
				else if (sts.srch_done) state_n = ST_FETCH;
				else state_n = ST_SWAIT;
			end
			ST_SWAIT: state_n = ST_SRCH;
			ST_FETCH: state_n = ST_FWAIT;
			ST_FWAIT: state_n = ST_M1;
			ST_M1: state_n = ST_M2;
			ST_M2: state_n = ST_M3;
			ST_M3: state_n = ST_DONE;
			ST_DONE: state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: ctl.load = start;
			ST_WRITE: begin
				ctl.wr = !sts.is_eval;
				ctl.rd_first = sts.is_eval;
			end
			ST_CHK0: begin
				ctl.chk_first = 1'b1;
				ctl.rd_last = 1'b1;
			end
			ST_CHKN: begin
				ctl.chk_last = 1'b1;
				ctl.rd_mid = 1'b1;
			end
			ST_SRCH: ctl.step = !(sts.below || sts.above) && !sts.srch_done;
			ST_SWAIT: ctl.rd_mid = 1'b1;
			ST_FETCH: ctl.rd_seg = 1'b1;
			ST_FWAIT: ctl.cap_seg = 1'b1;
			ST_M1: ctl.m1 = 1'b1;
			ST_M2: ctl.m2 = 1'b1;
			ST_M3: ctl.m3 = 1'b1;
			ST_DONE: ctl.fin = 1'b1;
			default: ctl = '0;
		endcase
	end
endmodule

@@ src/cse_dpath.sv @@
`timescale 1ns / 1ps
module cse_dpath #(
	parameter int MaxKnots = cse_pkg::MaxKnotsDef
) (
	input logic clk,
	input logic arst_n,
	input cse_pkg::in_item_t item,
	input logic [6:0] num_knots,
	input cse_pkg::ctl_t ctl,
	output cse_pkg::sts_t sts,
	output logic done,
	output cse_pkg::out_item_t res
);
	import cse_pkg::*;
	localparam int Aw = $clog2(MaxKnots);
	localparam int Cw = Aw + 1;

	in_item_t it_q;
	logic [Cw-1:0] n_q, lo_q, hi_q, mid;
	logic [Aw-1:0] raddr, waddr;
	logic [31:0] rk, ra, rb, rc, rd, rb2;
	logic [Aw-1:0] raddr2_q;
	logic below_q, above_q;
	logic signed [31:0] a_q, b_q, c_q, d_q, bl_q;
	logic signed [32:0] dx_q;
	logic signed [31:0] s1_q, s2_q;
	logic signed [31:0] vq, d1q, d2q, d3q;
	logic [Aw-1:0] seg_q;
	logic wr_ok;
	logic [Cw-1:0] nk;
	logic [Cw-1:0] sg;

	assign waddr = Aw'(it_q.entry_index);
	// entries beyond the table are dropped
	assign wr_ok = (MaxKnots >= 64) || (int'(it_q.entry_index) < MaxKnots);
	assign mid = Cw'((lo_q + hi_q) >> 1);

	always_comb begin
		if (num_knots < 7'd2) nk = Cw'(2);
		else if (int'(num_knots) > MaxKnots) nk = Cw'(MaxKnots);
		else nk = Cw'(num_knots);
	end

	always_comb begin
		sg = (lo_q == '0) ? '0 : Cw'(lo_q - 1'b1);
		if (sg > Cw'(n_q - 2'd2)) sg = Cw'(n_q - 2'd2);
	end

	// read address is issued in the cycle before the data is used
	always_comb begin
		raddr = '0;
		if (ctl.rd_last) raddr = Aw'(n_q - 1'b1);
		else if (ctl.chk_last || ctl.rd_mid) raddr = Aw'(mid);
		else if (ctl.rd_seg) raddr = Aw'(sg);
	end

	cse_ram #(.Width(32), .Depth(MaxKnots)) u_k (.clk, .we(ctl.wr && wr_ok),
		.waddr, .wdata(it_q.knot_pos), .raddr(raddr), .rdata(rk));
	cse_ram #(.Width(32), .Depth(MaxKnots)) u_a (.clk, .we(ctl.wr && wr_ok),
		.waddr, .wdata(it_q.coef_a), .raddr(raddr), .rdata(ra));
	cse_ram #(.Width(32), .Depth(MaxKnots)) u_b (.clk, .we(ctl.wr && wr_ok),
		.waddr, .wdata(it_q.coef_b), .raddr(raddr), .rdata(rb));
	cse_ram #(.Width(32), .Depth(MaxKnots)) u_b2 (.clk, .we(ctl.wr && wr_ok),
		.waddr, .wdata(it_q.coef_b), .raddr(raddr2_q), .rdata(rb2));
	cse_ram #(.Width(32), .Depth(MaxKnots)) u_c (.clk, .we(ctl.wr && wr_ok),
		.waddr, .wdata(it_q.coef_c), .raddr(raddr), .rdata(rc));
	cse_ram #(.Width(32), .Depth(MaxKnots)) u_d (.clk, .we(ctl.wr && wr_ok),
		.waddr, .wdata(it_q.coef_d), .raddr(raddr), .rdata(rd));

	assign sts.is_eval = (it_q.command == CmdEval);
	assign sts.below = below_q;
	assign sts.above = above_q;
	assign sts.srch_done = !(lo_q < hi_q);

	// shared multiplier product, one per multiply step
	logic signed [64:0] prod;
	logic signed [32:0] mul_a;
	always_comb begin
		mul_a = 33'(d_q);
		if (ctl.m2 || ctl.m3) mul_a = 33'(s1_q);
		prod = 65'(mul_a) * 65'(dx_q);
	end
	logic signed [48:0] r;
	assign r = rnd16(prod);

	always_ff @(posedge clk) begin
		if (ctl.load) it_q <= item;
		if (ctl.rd_first) begin
			n_q <= nk;
			lo_q <= '0;
			hi_q <= nk;
			raddr2_q <= Aw'(nk - 2'd2);
		end
		if (ctl.chk_first) begin
			below_q <= $signed(it_q.query_t) < $signed(rk);
			a_q <= ra; bl_q <= rb;
		end
		if (ctl.chk_last) begin
			above_q <= !below_q && ($signed(it_q.query_t) > $signed(rk));
			if (!below_q) begin a_q <= ra; bl_q <= rb2; end
		end
		if (ctl.step) begin
			if ($signed(rk) < $signed(it_q.query_t)) lo_q <= Cw'(mid + 1'b1);
			else hi_q <= mid;
		end
		if (ctl.rd_seg) seg_q <= Aw'(sg);
		if (ctl.cap_seg) begin
			a_q <= ra; b_q <= rb; c_q <= rc; d_q <= rd;
			dx_q <= 33'($signed(it_q.query_t)) - 33'($signed(rk));
		end
		if (ctl.m1) begin
			s1_q <= sat49(52'(r) + 52'(c_q));
			s2_q <= sat49(52'(r) * 52'sd3 + 52'(c_q) * 52'sd2);
			d2q <= sat49(52'(r) * 52'sd6 + 52'(c_q) * 52'sd2);
			d3q <= sat32(36'(d_q) * 36'sd6);
		end
		if (ctl.m2) begin
			s1_q <= sat49(52'(r) + 52'(b_q));
			// first derivative product runs beside the value chain
			d1q <= sat49(52'(rnd16(65'(s2_q) * 65'(dx_q))) + 52'(b_q));
		end
		if (ctl.m3) begin
			vq <= sat49(52'(r) + 52'(a_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= ctl.fin;
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			if (below_q || above_q) begin
				res.value <= a_q;
				res.first_deriv <= bl_q;
				res.second_deriv <= '0;
				res.third_deriv <= '0;
				res.range_status <= below_q ? RangeBelow : RangeAbove;
				res.segment_index <= '0;
			end else begin
				res.value <= vq;
				res.first_deriv <= d1q;
				res.second_deriv <= d2q;
				res.third_deriv <= d3q;
				res.range_status <= RangeIn;
				res.segment_index <= 6'(seg_q);
			end
		end
	end
endmodule

@@ src/cubic_spline_evaluator.sv @@
`timescale 1ns / 1ps
// cubic spline evaluator
// command channel: start with cmd, accepted when start is high and busy low
// command write (0) stores one table entry, busy for one cycle, no result
// command evaluate (1) gives one result on res, marked by done for one cycle
// evaluate steps: range checks against the first and last knots, k bisection steps
// (at most ceil(log2(n+1)), 7 for 64 knots), segment fetch, 3 multiply steps, done
// out-of-range queries skip the search and go from the range checks to done
// busy is low in the done cycle, so the next transaction can be taken there
// configuration: apb port, register num_knots at address 0, reset value 2
// pready is always high, writes complete on the access cycle
// reset returns the controller to idle and sets num_knots to 2; the table is undefined until written
// the receiver cannot stall: results are marked by done for exactly one cycle
// values are q16.16, products round to nearest and saturate to 32 bits
module cubic_spline_evaluator #(
	parameter int MaxKnots = cse_pkg::MaxKnotsDef
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input cse_pkg::in_item_t cmd,
	output logic done,
	output cse_pkg::out_item_t res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [0:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import cse_pkg::*;
	`include "cubic_spline_evaluator_defines.svh"

	logic [6:0] num_knots_q;
	ctl_t ctl;
	sts_t sts;

	assign pready = 1'b1;
	// register write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) num_knots_q <= 7'(NumKnotsReset);
		else if (psel && penable && pwrite && paddr == RegNumKnots)
			num_knots_q <= pwdata[6:0];
	end
	assign prdata = (paddr == RegNumKnots) ? {25'd0, num_knots_q} : 32'd0;

	cse_ctrl u_ctrl (.clk, .arst_n, .start, .sts, .busy, .ctl);
	cse_dpath #(.MaxKnots(MaxKnots)) u_dp (.clk, .arst_n, .item(cmd),
		.num_knots(num_knots_q), .ctl, .sts, .done, .res);

	`CSE_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`CSE_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`CSE_ASSERT_NEXT(a_load_busy, clk, arst_n, start && !busy, busy)
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// spline evaluator regression: a queue of commands feeds a clocked driver,
// an internal spline model predicts every evaluate result, and a clocked
// monitor compares each done strobe against the oldest prediction
module tb;
	import cse_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t cmd;
	logic done;
	out_item_t res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [0:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	cubic_spline_evaluator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .res(res), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// commands waiting for the driver and results waiting for the monitor
	in_item_t cmd_backlog[$];
	out_item_t spline_results[$];

	// model copy of the table and the knot count register
	logic signed [31:0] knot_tbl[64];
	logic signed [31:0] a_tbl[64];
	logic signed [31:0] b_tbl[64];
	logic signed [31:0] c_tbl[64];
	logic signed [31:0] d_tbl[64];
	logic [6:0] knot_count;

	int errors;
	int gap_left;
	bit no_gaps;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// q16.16 product rounding: floor((p + 2^15) / 2^16)
	function automatic logic signed [79:0] q_round(input logic signed [79:0] p);
		logic signed [79:0] v;
		v = p + 80'sd32768;
		return v >>> 16;
	endfunction

	function automatic logic signed [79:0] q_sat(input logic signed [79:0] v);
		if (v > 80'sd2147483647) return 80'sd2147483647;
		if (v < -80'sd2147483648) return -80'sd2147483648;
		return v;
	endfunction

	// spline lookup and horner evaluation for one query point
	function automatic out_item_t spline_eval(input logic signed [31:0] t);
		out_item_t r;
		int n, lo, hi, mid, seg;
		logic signed [79:0] tt, dx, a, b, c, d, p, s;
		n = int'(knot_count);
		if (n < 2) n = 2;
		if (n > 64) n = 64;
		tt = 80'(t);
		r = '0;
		if (t < knot_tbl[0]) begin
			r.value = a_tbl[0];
			r.first_deriv = b_tbl[0];
			r.range_status = RangeBelow;
		end else if (t > knot_tbl[n-1]) begin
			r.value = a_tbl[n-1];
			r.first_deriv = b_tbl[n-2];
			r.range_status = RangeAbove;
		end else begin
			// bisection for the first knot at or above t
			lo = 0;
			hi = n;
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if (knot_tbl[mid] < t) lo = mid + 1;
				else hi = mid;
			end
			seg = (lo == 0) ? 0 : lo - 1;
			if (seg > n - 2) seg = n - 2;
			dx = tt - 80'(knot_tbl[seg]);
			a = 80'(a_tbl[seg]);
			b = 80'(b_tbl[seg]);
			c = 80'(c_tbl[seg]);
			d = 80'(d_tbl[seg]);
			p = q_round(d * dx);
			s = q_sat(p + c);
			s = q_sat(q_round(s * dx) + b);
			r.value = 32'(q_sat(q_round(s * dx) + a));
			s = q_sat(80'sd3 * p + 80'sd2 * c);
			r.first_deriv = 32'(q_sat(q_round(s * dx) + b));
			r.second_deriv = 32'(q_sat(80'sd6 * p + 80'sd2 * c));
			r.third_deriv = 32'(q_sat(80'sd6 * d));
			r.range_status = RangeIn;
			r.segment_index = seg[5:0];
		end
		return r;
	endfunction

	// most gaps short, a few long, none at all in burst phases
	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver: a transaction is taken at an edge with start high and busy low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				if (cmd.command == CmdWrite) begin
					knot_tbl[cmd.entry_index] = cmd.knot_pos;
					a_tbl[cmd.entry_index] = cmd.coef_a;
					b_tbl[cmd.entry_index] = cmd.coef_b;
					c_tbl[cmd.entry_index] = cmd.coef_c;
					d_tbl[cmd.entry_index] = cmd.coef_d;
				end else begin
					spline_results = {spline_results, spline_eval(cmd.query_t)};
				end
				void'(cmd_backlog.pop_front());
				gap_left = pick_gap();
			end
			if (start && busy) begin
				// hold the pending transaction
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_backlog.size() > 0) begin
				start <= 1'b1;
				cmd <= cmd_backlog[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: results cannot be held off, so check every done strobe
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (spline_results.size() == 0) begin
				$error("result with nothing predicted");
				errors++;
			end else begin
				out_item_t e;
				e = spline_results.pop_front();
				if (res.value !== e.value) begin
					$error("value exp %0d got %0d", e.value, res.value);
					errors++;
				end
				if (res.first_deriv !== e.first_deriv) begin
					$error("first_deriv exp %0d got %0d", e.first_deriv, res.first_deriv);
					errors++;
				end
				if (res.second_deriv !== e.second_deriv) begin
					$error("second_deriv exp %0d got %0d", e.second_deriv, res.second_deriv);
					errors++;
				end
				if (res.third_deriv !== e.third_deriv) begin
					$error("third_deriv exp %0d got %0d", e.third_deriv, res.third_deriv);
					errors++;
				end
				if (res.range_status !== e.range_status) begin
					$error("range_status exp %0d got %0d", e.range_status, res.range_status);
					errors++;
				end
				if (res.segment_index !== e.segment_index) begin
					$error("segment_index exp %0d got %0d", e.segment_index,
						res.segment_index);
					errors++;
				end
			end
		end
	end

	// watchdog on total cycles
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_write(input int idx, input logic [31:0] k, input logic [31:0] a,
		input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		in_item_t it;
		it = '0;
		it.command = CmdWrite;
		it.entry_index = idx[5:0];
		it.knot_pos = k;
		it.coef_a = a;
		it.coef_b = b;
		it.coef_c = c;
		it.coef_d = d;
		it.query_t = $urandom;
		cmd_backlog = {cmd_backlog, it};
	endtask

	task automatic push_eval(input logic [31:0] t);
		in_item_t it;
		it.command = CmdEval;
		it.entry_index = 6'($urandom);
		it.knot_pos = $urandom;
		it.coef_a = $urandom;
		it.coef_b = $urandom;
		it.coef_c = $urandom;
		it.coef_d = $urandom;
		it.query_t = t;
		cmd_backlog = {cmd_backlog, it};
	endtask

	// coefficient with a random magnitude so both saturated and exact paths occur
	function automatic logic [31:0] rand_coef();
		logic signed [31:0] v;
		v = $urandom;
		return v >>> $urandom_range(0, 31);
	endfunction

	// wait until all transactions are done, then let writes drain
	task automatic drain();
		while (cmd_backlog.size() != 0 || spline_results.size() != 0 || start)
			@(posedge clk);
		repeat (30) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// apb setup then access cycle; register updates on the access edge
	task automatic reg_write(input logic [6:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= RegNumKnots;
		pwdata <= {$urandom_range(0, 1) ? 25'h1ffffff : 25'h0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		knot_count = v;
	endtask

	// load all 64 entries with sorted knots over a random span
	task automatic load_table();
		int kq[$];
		int span_sh, base;
		span_sh = $urandom_range(0, 12);
		base = $urandom;
		for (int i = 0; i < 64; i++) begin
			if (span_sh == 0) kq = {kq, int'($urandom)};
			else kq = {kq, base + int'($urandom >> span_sh)};
		end
		if (span_sh != 0) begin
			// keep the window from wrapping
			foreach (kq[i]) kq[i] = (base >>> 1) + int'($urandom >> span_sh);
		end
		kq.sort();
		for (int i = 0; i < 64; i++)
			push_write(i, kq[i], rand_coef(), rand_coef(), rand_coef(), rand_coef());
	endtask

	logic [6:0] count_plan[7] = '{7'd64, 7'd0, 7'd1, 7'd127, 7'd33, 7'd3, 7'd2};

	initial begin
		logic signed [31:0] k;
		int r;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		cycles = 0;
		no_gaps = 1'b0;
		knot_count = NumKnotsReset;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: evenly spaced table, extreme coefficients at the edges
		for (int i = 0; i < 64; i++)
			push_write(i, -32'sd1048576 + i * 32'sd65536, i * 32'sd4096, -i * 32'sd100,
				32'sd65536, 32'sd32768);
		push_write(0, 32'h8000_0001, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff);
		push_write(63, 32'h7fff_fffe, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000);
		// default two knots: at both knots, below, above
		push_eval(32'h8000_0000);
		push_eval(32'h8000_0001);
		push_eval(-32'sd1048576 + 32'sd65536);
		push_eval(32'h0000_0000);
		push_eval(32'h7fff_ffff);
		drain();
		reg_write(7'd64);
		push_eval(32'h8000_0000);
		push_eval(32'h8000_0001);
		push_eval(32'h7fff_fffe);
		push_eval(32'h7fff_ffff);
		push_eval(32'h4000_0000);
		push_eval(-32'sd1048576 + 32'sd65536 * 10);
		push_eval(-32'sd1048576 + 32'sd65536 * 10 + 32'sd1);
		push_eval(-32'sd1048576 + 32'sd65536 * 10 - 32'sd1);
		push_eval(-32'sd1048576 + 32'sd65536 * 62 + 32'sd32768);
		drain();

		// random phases across knot count settings
		foreach (count_plan[ph]) begin
			no_gaps = (ph % 3 == 2);
			reg_write(ph == 4 ? 7'($urandom_range(4, 63)) : count_plan[ph]);
			load_table();
			for (int j = 0; j < 85; j++) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					// single rewrite, may break the knot order
					push_write($urandom_range(0, 63), $urandom, rand_coef(), rand_coef(),
						rand_coef(), rand_coef());
				end else if (r < 20) begin
					push_eval($urandom);
				end else begin
					// queries near a stored knot, including the current rewrites
					while (cmd_backlog.size() >= 4) @(posedge clk);
					k = knot_tbl[$urandom_range(0, 63)];
					push_eval(k + $signed($urandom_range(0, 131072)) - 32'sd65536);
				end
			end
			drain();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && spline_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
